@@ hw/rtl/rbl_pkg.sv @@
package rbl_pkg;

  // Default widths
  localparam int LEN_BITS_DEF  = 24;
  localparam int FRAC_BITS_DEF = 24;

  // Fixed datapath widths
  localparam int CFG_W  = 32;
  localparam int LOG_W  = 40;
  localparam int MAG_W  = LOG_W + 1;
  localparam int PROD_W = MAG_W + 32;

  // ln(2) in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic signed [LOG_W-1:0] LOG_MAX = {1'b0, {(LOG_W-1){1'b1}}};
  localparam logic signed [LOG_W-1:0] LOG_MIN = {1'b1, {(LOG_W-1){1'b0}}};

  localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

  // Register reset values
  localparam logic [CFG_W-1:0] INV_SCALE_RST   = 32'd16777216;
  localparam logic [CFG_W-1:0] EDGE_MARGIN_RST = 32'd8090;

  // Register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_INV_SCALE   = 1'b0;
  localparam cfg_idx_t CFG_EDGE_MARGIN = 1'b1;

  typedef struct packed {
    logic [23:0] read_pos;
    logic [23:0] gene_len;
    logic [31:0] inv_freq;
    logic        last_read;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] neg2_loglik;
    logic               zero_density;
    logic               run_last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic set_zero;
    logic load_base;
    logic ln_start;
    logic ln_norm;
    logic ln_write;
    logic ln_min;
    logic mul_ln2;
    logic term_start;
    logic accumulate;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic zero_seen;
    logic dens_zero;
    logic len_changed;
    logic cache_hit;
    logic last;
    logic log_done;
    logic log_zero;
    logic mul_done;
    logic out_busy;
  } dp_status_t;

endpackage

@@ hw/rtl/rbl_log2.sv @@
module rbl_log2 import rbl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [63:0]             value,
  output logic signed [MAG_W-1:0] l2,
  output logic                    done,
  output logic                    is_zero
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_NORM = 3'b010,
    L_SQ   = 3'b100
  } log_state_t;

  log_state_t state;
  logic [63:0]           m;
  logic [5:0]            k;
  logic [31:0]           y;
  logic [FRAC_BITS-1:0]  frac;
  logic [CNT_W-1:0]      cnt;
  logic                  zero_r;
  logic                  done_r;

  logic [63:0]            sq;
  logic [32:0]            sq_sh;
  logic signed [MAG_W-1:0] exp_s;

  // Q1.31 square, truncated
  assign sq    = 64'(y) * 64'(y);
  assign sq_sh = sq[63:31];

  // log2 = (e - F) * 2^F + frac, with e = 63 - k
  assign exp_s   = MAG_W'(63 - int'(k) - FRAC_BITS);
  assign l2      = (exp_s <<< FRAC_BITS) + $signed(MAG_W'(frac));
  assign done    = done_r;
  assign is_zero = zero_r;

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (rst) begin
      state  <= L_IDLE;
      zero_r <= 1'b0;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            m      <= value;
            k      <= '0;
            zero_r <= (value == 64'd0);
            state  <= L_NORM;
          end
        end
        // leading-one search: a byte at a time, then bit by bit
        L_NORM: begin
          if (zero_r) begin
            done_r <= 1'b1;
            state  <= L_IDLE;
          end else if (m[63]) begin
            y     <= m[63:32];
            frac  <= '0;
            cnt   <= '0;
            state <= L_SQ;
          end else if (m[63:56] == 8'd0) begin
            m <= m << 8;
            k <= k + 6'd8;
          end else begin
            m <= m << 1;
            k <= k + 6'd1;
          end
        end
        // one fraction bit per square
        L_SQ: begin
          if (sq_sh[32]) begin
            y    <= sq_sh[32:1];
            frac <= {frac[FRAC_BITS-2:0], 1'b1};
          end else begin
            y    <= sq_sh[31:0];
            frac <= {frac[FRAC_BITS-2:0], 1'b0};
          end
          if (cnt == CNT_W'(FRAC_BITS - 1)) begin
            done_r <= 1'b1;
            state  <= L_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/rbl_mul.sv @@
module rbl_mul import rbl_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] a,
  input  logic [31:0]      b,
  input  logic             use_ln2,
  output logic [63:0]      res,
  output logic             done
);

  localparam int HI_W   = MAG_W - 32;
  localparam int HP_W   = HI_W + 32;
  localparam int RND_W  = PROD_W + 1;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_LO   = 4'b0010,
    M_HI   = 4'b0100,
    M_RND  = 4'b1000
  } mul_state_t;

  mul_state_t state;
  logic [MAG_W-1:0]  a_r;
  logic [31:0]       b_r;
  logic              ln2_r;
  logic [PROD_W-1:0] p;
  logic [63:0]       res_r;
  logic              done_r;

  logic [63:0]      lo_prod;
  logic [HP_W-1:0]  hi_prod;
  logic [RND_W-1:0] rnd_sum;
  logic [RND_W-1:0] shifted;

  // two partial products of the magnitude against b
  assign lo_prod = 64'(a_r[31:0]) * 64'(b_r);
  assign hi_prod = HP_W'(a_r[MAG_W-1:32]) * HP_W'(b_r);

  // round half up, then shift out the fraction
  assign rnd_sum = RND_W'(p) + (ln2_r ? (RND_W'(1) << 31) : (RND_W'(1) << (FRAC_BITS - 1)));
  assign shifted = ln2_r ? (rnd_sum >> 32) : (rnd_sum >> FRAC_BITS);

  assign res  = res_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (rst) begin
      state <= M_IDLE;
    end else begin
      unique case (state)
        M_IDLE: begin
          if (start) begin
            a_r   <= a;
            b_r   <= b;
            ln2_r <= use_ln2;
            state <= M_LO;
          end
        end
        M_LO: begin
          p     <= PROD_W'(lo_prod);
          state <= M_HI;
        end
        M_HI: begin
          p     <= p + {hi_prod, 32'd0};
          state <= M_RND;
        end
        // result stays below 2^62, no saturation needed
        M_RND: begin
          res_r  <= shifted[63:0];
          done_r <= 1'b1;
          state  <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/rbl_datapath.sv @@
module rbl_datapath import rbl_pkg::*; #(
  parameter int LEN_BITS  = LEN_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  in_item_t         in_item,
  input  ctl_cmd_t         cmd,
  output dp_status_t       status,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  localparam int SUM_W  = ((LEN_BITS + 8 > CFG_W) ? LEN_BITS + 8 : CFG_W) + 1;
  localparam int BASE_W = LEN_BITS + CFG_W;
  localparam int DENS_W = CFG_W + 1;

  // configuration
  logic [CFG_W-1:0] inv_scale;
  logic [CFG_W-1:0] edge_margin;

  // current item
  logic [LEN_BITS-1:0] x_pos;
  logic [LEN_BITS-1:0] g_len;
  logic [31:0]         weight;
  logic                last_r;

  // run state
  logic [LEN_BITS-1:0]      prev_len;
  logic signed [LOG_W-1:0]  log_norm;
  logic signed [63:0]       log_sum;
  logic                     zero_seen;

  logic [BASE_W-1:0]        base;
  logic signed [LOG_W-1:0]  cache_ln [2];
  logic [1:0]               cache_ok;
  logic                     mul_neg;
  logic                     out_valid_r;
  out_item_t                out_item_r;

  logic [31:0]             x32;
  logic [31:0]             l32;
  logic [SUM_W-1:0]        xq;
  logic [SUM_W-1:0]        hq;
  logic [SUM_W-1:0]        lq;
  logic                    inner;
  logic [DENS_W-1:0]       dens;
  logic [63:0]             lq64;
  logic [63:0]             two_h;
  logic [63:0]             edge_diff;
  logic [63:0]             edge_term;
  logic [64:0]             norm_sum;
  logic [63:0]             norm;
  logic [63:0]             log_in;
  logic signed [MAG_W-1:0] l2;
  logic                    log_done;
  logic                    log_zero;
  logic signed [MAG_W-1:0] diff;
  logic [MAG_W-1:0]        diff_mag;
  logic [MAG_W-1:0]        l2_mag;
  logic [MAG_W-1:0]        mul_a;
  logic [31:0]             mul_b;
  logic [63:0]             mul_res;
  logic                    mul_done;
  logic signed [64:0]      sres;
  logic signed [LOG_W-1:0] ln_val;
  logic signed [64:0]      acc;
  logic signed [63:0]      acc_sat;
  logic signed [63:0]      result;

  assign x32 = {8'd0, in_item.read_pos};
  assign l32 = {8'd0, in_item.gene_len};

  // inner region test and read density
  assign xq    = SUM_W'({x_pos, 8'd0});
  assign hq    = SUM_W'(edge_margin);
  assign lq    = SUM_W'({g_len, 8'd0});
  assign inner = (xq > hq) && ((xq + hq) < lq);
  assign dens  = DENS_W'(inv_scale) + (inner ? (DENS_W'(1) << FRAC_BITS) : DENS_W'(0));

  // gene norm: l/d plus the length inside the end margins, saturated
  assign lq64      = 64'(g_len) << 8;
  assign two_h     = 64'(edge_margin) << 1;
  assign edge_diff = lq64 - two_h;
  assign edge_term = (lq64 <= two_h) ? 64'd0 :
                     ((edge_diff >> (72 - FRAC_BITS)) != 64'd0) ? {64{1'b1}} :
                     (edge_diff << (FRAC_BITS - 8));
  assign norm_sum  = 65'(base) + 65'(edge_term);
  assign norm      = norm_sum[64] ? {64{1'b1}} : norm_sum[63:0];

  assign log_in = cmd.ln_norm ? norm : 64'(dens);

  rbl_log2 #(
    .FRAC_BITS(FRAC_BITS)
  ) u_log2 (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.ln_start),
    .value   (log_in),
    .l2      (l2),
    .done    (log_done),
    .is_zero (log_zero)
  );

  // multiplier operands: log2 by ln2, or log difference by weight
  assign diff     = MAG_W'(cache_ln[inner]) - MAG_W'(log_norm);
  assign diff_mag = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign l2_mag   = l2[MAG_W-1] ? MAG_W'(-l2) : MAG_W'(l2);
  assign mul_a    = cmd.mul_ln2 ? l2_mag : diff_mag;
  assign mul_b    = cmd.mul_ln2 ? LN2_Q32 : weight;

  rbl_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_ln2 | cmd.term_start),
    .a       (mul_a),
    .b       (mul_b),
    .use_ln2 (cmd.mul_ln2),
    .res     (mul_res),
    .done    (mul_done)
  );

  // signed product, clamped for logs
  assign sres = mul_neg ? -$signed({1'b0, mul_res}) : $signed({1'b0, mul_res});

  always_comb begin
    if (cmd.ln_min) begin
      ln_val = LOG_MIN;
    end else if (sres > 65'(LOG_MAX)) begin
      ln_val = LOG_MAX;
    end else if (sres < 65'(LOG_MIN)) begin
      ln_val = LOG_MIN;
    end else begin
      ln_val = sres[LOG_W-1:0];
    end
  end

  // saturating accumulate
  assign acc = 65'(log_sum) + sres;
  always_comb begin
    if (acc[64] != acc[63]) begin
      acc_sat = acc[64] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_sat = acc[63:0];
    end
  end

  // final -2 * sum, saturated; max after a zero density
  always_comb begin
    if (zero_seen) begin
      result = SUM_MAX;
    end else if (log_sum >= (SUM_MAX >>> 1) + 64'sd1) begin
      result = SUM_MIN;
    end else if (log_sum <= (SUM_MIN >>> 1)) begin
      result = SUM_MAX;
    end else begin
      result = -(log_sum <<< 1);
    end
  end

  assign status.zero_seen   = zero_seen;
  assign status.dens_zero   = (dens == DENS_W'(0));
  assign status.len_changed = (g_len != prev_len);
  assign status.cache_hit   = cache_ok[inner];
  assign status.last        = last_r;
  assign status.log_done    = log_done;
  assign status.log_zero    = log_zero;
  assign status.mul_done    = mul_done;
  assign status.out_busy    = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      x_pos  <= x32[LEN_BITS-1:0];
      g_len  <= l32[LEN_BITS-1:0];
      weight <= in_item.inv_freq;
      last_r <= in_item.last_read;
    end
    if (cmd.load_base) begin
      base <= BASE_W'(g_len) * BASE_W'(inv_scale);
    end
    if (cmd.mul_ln2) begin
      mul_neg <= l2[MAG_W-1];
    end else if (cmd.term_start) begin
      mul_neg <= diff[MAG_W-1];
    end
    if (cmd.ln_write && !cmd.ln_norm) begin
      cache_ln[inner] <= ln_val;
    end
    if (cmd.emit) begin
      out_item_r.neg2_loglik  <= result;
      out_item_r.zero_density <= zero_seen;
      out_item_r.run_last     <= 1'b1;
    end
  end

  // configuration, run state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_scale   <= INV_SCALE_RST;
      edge_margin <= EDGE_MARGIN_RST;
      prev_len    <= '0;
      log_norm    <= '0;
      log_sum     <= '0;
      zero_seen   <= 1'b0;
      cache_ok    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cache_ok <= '0;
        unique case (cfg_index)
          CFG_INV_SCALE:   inv_scale   <= cfg_data;
          CFG_EDGE_MARGIN: edge_margin <= cfg_data;
        endcase
      end
      if (cmd.set_zero) begin
        zero_seen <= 1'b1;
      end
      if (cmd.ln_write) begin
        if (cmd.ln_norm) begin
          log_norm <= ln_val;
          prev_len <= g_len;
        end else begin
          cache_ok[inner] <= 1'b1;
        end
      end
      if (cmd.accumulate) begin
        log_sum <= acc_sat;
      end
      if (cmd.emit) begin
        prev_len  <= '0;
        log_norm  <= '0;
        log_sum   <= '0;
        zero_seen <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/rbl_ctrl.sv @@
module rbl_ctrl import rbl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_CHECK    = 8'b0000_0010,
    S_NORM_MUL = 8'b0000_0100,
    S_LN_LOG   = 8'b0000_1000,
    S_LN_MUL   = 8'b0001_0000,
    S_DENS     = 8'b0010_0000,
    S_TERM     = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } ctl_state_t;

  ctl_state_t state, state_next;
  logic       ln_norm, ln_norm_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    ln_norm_next = ln_norm;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      // skip after a zero density; recompute the norm on a new gene
      S_CHECK: begin
        if (status.zero_seen) begin
          state_next = S_FIN;
        end else if (status.dens_zero) begin
          cmd.set_zero = 1'b1;
          state_next   = S_FIN;
        end else if (status.len_changed) begin
          cmd.load_base = 1'b1;
          state_next    = S_NORM_MUL;
        end else begin
          state_next = S_DENS;
        end
      end
      S_NORM_MUL: begin
        cmd.ln_start = 1'b1;
        cmd.ln_norm  = 1'b1;
        ln_norm_next = 1'b1;
        state_next   = S_LN_LOG;
      end
      S_LN_LOG: begin
        cmd.ln_norm = ln_norm;
        if (status.log_done) begin
          if (status.log_zero) begin
            cmd.ln_write = 1'b1;
            cmd.ln_min   = 1'b1;
            state_next   = S_DENS;
          end else begin
            cmd.mul_ln2 = 1'b1;
            state_next  = S_LN_MUL;
          end
        end
      end
      S_LN_MUL: begin
        cmd.ln_norm = ln_norm;
        if (status.mul_done) begin
          cmd.ln_write = 1'b1;
          state_next   = S_DENS;
        end
      end
      // density log from the cache, filled on a miss
      S_DENS: begin
        if (status.cache_hit) begin
          cmd.term_start = 1'b1;
          state_next     = S_TERM;
        end else begin
          cmd.ln_start = 1'b1;
          ln_norm_next = 1'b0;
          state_next   = S_LN_LOG;
        end
      end
      S_TERM: begin
        if (status.mul_done) begin
          cmd.accumulate = 1'b1;
          state_next     = S_FIN;
        end
      end
      // last read: wait for the output register to free up
      S_FIN: begin
        if (!status.last) begin
          state_next = S_IDLE;
        end else if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ln_norm <= 1'b0;
    end else begin
      state   <= state_next;
      ln_norm <= ln_norm_next;
    end
  end

endmodule

@@ hw/rtl/read_bias_loglik_uniform.sv @@
// Weighted log-likelihood of read positions under a uniform fragmentation
// model with excluded gene ends. One read is taken at a time. A read of the
// same gene as the one before, whose density log is already known, is
// paced by the two-pass 41x32 multiply of the weighted term. A new gene
// length adds an iterative natural log of the gene norm: a leading-one
// search, FRAC_BITS squaring steps (24 by default) and a multiply by ln2.
// The two density logs (inside and outside the end margins) are cached
// and each costs one such log on first use after reset or a register
// write. The result of a run appears on the output on the read marked
// last; the output register holds it while the next run proceeds.
module read_bias_loglik_uniform import rbl_pkg::*; #(
  parameter int LEN_BITS  = LEN_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  rbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rbl_datapath #(
    .LEN_BITS  (LEN_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ tb/sv/read_bias_loglik_uniform_tb.sv @@
`timescale 1ns / 100ps

module read_bias_loglik_uniform_tb;
  import rbl_pkg::*;

  // Bit-accurate predictor of the weighted log-likelihood
  class loglik_scoreboard;
    bit [31:0] inv_scale;
    bit [31:0] margin;
    bit [23:0] last_len;
    longint    norm_log;
    longint    acc;
    bit        dens_zero;
    out_item_t pending[$];
    int        errors;

    function void clear_run();
      last_len  = '0;
      norm_log  = 0;
      acc       = 0;
      dens_zero = 1'b0;
    endfunction

    function void reset();
      inv_scale = INV_SCALE_RST;
      margin    = EDGE_MARGIN_RST;
      clear_run();
    endfunction

    function void write_reg(cfg_idx_t idx, bit [31:0] val);
      if (idx == CFG_INV_SCALE) inv_scale = val;
      else margin = val;
    endfunction

    // (a*b + half) >> s, saturated to int64 max
    function longint unsigned round_mul(longint unsigned a, bit [31:0] b, int s);
      bit [127:0] p;
      p = 128'(a) * 128'(b) + (128'd1 << (s - 1));
      p = p >> s;
      if (p > 128'h7FFF_FFFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF_FFFF;
      return p[63:0];
    endfunction

    function longint signed_round_mul(longint v, bit [31:0] b, int s);
      longint unsigned m, r;
      m = (v < 0) ? -v : v;
      r = round_mul(m, b, s);
      return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function longint sat_sum(longint a, longint b);
      longint s;
      s = a + b;
      if (b > 0 && s < a) return SUM_MAX;
      if (b < 0 && s > a) return SUM_MIN;
      return s;
    endfunction

    // natural log of a Q.24 value via log2 by repeated squaring
    function longint nat_log(longint unsigned m);
      int e;
      longint unsigned y;
      longint fr, l2, r;
      if (m == 0) return longint'(LOG_MIN);
      e = 63;
      while (m[e] == 1'b0) e--;
      y = (e >= 31) ? (m >> (e - 31)) : (m << (31 - e));
      fr = 0;
      for (int i = 0; i < 24; i++) begin
        y = (y * y) >> 31;
        fr = fr * 2;
        if ((y >> 32) != 0) begin
          fr += 1;
          y >>= 1;
        end
      end
      l2 = (longint'(e) - 24) * (longint'(1) << 24) + fr;
      r = signed_round_mul(l2, LN2_Q32, 32);
      if (r > longint'(LOG_MAX)) r = longint'(LOG_MAX);
      if (r < longint'(LOG_MIN)) r = longint'(LOG_MIN);
      return r;
    endfunction

    function longint unsigned gene_norm(longint unsigned l);
      longint unsigned base, lq, two_h, diff, edge_t;
      base  = l * 64'(inv_scale);
      lq    = l << 8;
      two_h = 64'(margin) * 64'd2;
      if (lq > two_h) begin
        diff = lq - two_h;
        edge_t = ((diff >> 48) != 0) ? '1 : (diff << 16);
        base = (base > ~edge_t) ? '1 : base + edge_t;
      end
      return base;
    endfunction

    function void note_read(in_item_t it);
      longint unsigned xq, h, l, dens;
      longint diff, res;
      out_item_t o;
      bit inner;
      if (!dens_zero) begin
        l  = 64'(it.gene_len);
        xq = 64'(it.read_pos) << 8;
        h  = 64'(margin);
        inner = (xq > h) && (xq + h < (l << 8));
        dens = 64'(inv_scale) + (inner ? (64'd1 << 24) : 64'd0);
        if (dens == 0) dens_zero = 1'b1;
        else begin
          if (it.gene_len != last_len) begin
            norm_log = nat_log(gene_norm(l));
            last_len = it.gene_len;
          end
          diff = nat_log(dens) - norm_log;
          acc = sat_sum(acc, signed_round_mul(diff, it.inv_freq, 24));
        end
      end
      if (!it.last_read) return;
      if (dens_zero) res = SUM_MAX;
      else if (acc >= (longint'(1) << 62)) res = SUM_MIN;
      else if (acc <= -(longint'(1) << 62)) res = SUM_MAX;
      else res = -(acc * 2);
      o.neg2_loglik  = res;
      o.zero_density = dens_zero;
      o.run_last     = 1'b1;
      pending = {pending, o};
      clear_run();
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.neg2_loglik !== e.neg2_loglik) begin
        $display("%0t: neg2_loglik expected %0d actual %0d", $time,
                 e.neg2_loglik, got.neg2_loglik);
        errors++;
      end
      if (got.zero_density !== e.zero_density) begin
        $display("%0t: zero_density expected %0b actual %0b", $time,
                 e.zero_density, got.zero_density);
        errors++;
      end
      if (got.run_last !== e.run_last) begin
        $display("%0t: run_last expected %0b actual %0b", $time,
                 e.run_last, got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_index = CFG_INV_SCALE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  loglik_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  localparam int CYCLE_LIMIT = 2_000_000;

  read_bias_loglik_uniform u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

  always #1 clk = ~clk;

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("read_bias_loglik_uniform_tb: done, errors");
      $finish;
    end
  end

  // Result sampling and random receiver stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
  end
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // valid drops only in the idle loop or in wait_drained
  task automatic send_read(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_read(it);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t make_read(bit [23:0] l, bit is_last);
    in_item_t it;
    it.gene_len  = l;
    it.read_pos  = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(l));
    case ($urandom_range(3))
      0: it.inv_freq = $urandom;
      1: it.inv_freq = $urandom_range(32'h0400_0000);
      default: it.inv_freq = $urandom_range(32'h0100_0000);
    endcase
    it.last_read = is_last;
    return it;
  endfunction

  // A run: reads grouped by gene, last one closes it
  task automatic random_run(int n);
    bit [23:0] l;
    l = 24'($urandom_range(2000, 5));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(5))
          0: l = 24'($urandom);
          1: l = 24'($urandom_range(3));
          default: l = 24'($urandom_range(5000, 5));
        endcase
      end
      send_read(make_read(l, i == n - 1));
    end
  endtask

  task automatic phase(int runs);
    for (int r = 0; r < runs; r++) random_run(int'($urandom_range(12, 1)));
  endtask

  initial begin
    in_item_t it;
    sb.reset();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, inner/outer reads, zero length, zero density
    it = '{read_pos: 24'd100, gene_len: 24'd1000, inv_freq: 32'h0100_0000,
           last_read: 1'b0};
    send_read(it);
    it.read_pos = 24'd0;           send_read(it);
    it.read_pos = 24'hFFFFFF;      send_read(it);
    it.inv_freq = 32'hFFFF_FFFF;   send_read(it);
    it.gene_len = 24'hFFFFFF; it.read_pos = 24'h7FFFFF; send_read(it);
    it.inv_freq = 32'd0; it.last_read = 1'b1; send_read(it);
    // first read with zero length
    it = '{read_pos: 24'd0, gene_len: 24'd0, inv_freq: 32'h0100_0000,
           last_read: 1'b1};
    send_read(it);
    // large weights on a huge gene
    for (int i = 0; i < 6; i++) begin
      it = '{read_pos: 24'd1, gene_len: 24'hFFFFFF, inv_freq: 32'hFFFF_FFFF,
             last_read: (i == 5)};
      send_read(it);
    end
    wait_drained();
    // zero density and extreme margins
    write_reg(CFG_INV_SCALE, 32'd0);
    write_reg(CFG_EDGE_MARGIN, 32'd0);
    it = '{read_pos: 24'd5, gene_len: 24'd100, inv_freq: 32'h0100_0000,
           last_read: 1'b0};
    send_read(it);
    it.read_pos = 24'd0; send_read(it);   // outside: zero density
    it.read_pos = 24'd5; send_read(it);   // ignored
    it.last_read = 1'b1; send_read(it);
    wait_drained();
    write_reg(CFG_INV_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_EDGE_MARGIN, 32'hFFFF_FFFF);
    it = '{read_pos: 24'hFFFFFF, gene_len: 24'hFFFFFF, inv_freq: 32'h0100_0000,
           last_read: 1'b1};
    send_read(it);
    wait_drained();

    // Random phases under different idle mixes and register settings
    send_idle_pct = 15; recv_idle_pct = 77;
    write_reg(CFG_INV_SCALE, INV_SCALE_RST);
    write_reg(CFG_EDGE_MARGIN, EDGE_MARGIN_RST);
    phase(100);
    // mid-run register change is legal only when idle, so drain first
    wait_drained();
    send_idle_pct = 77; recv_idle_pct = 15;
    write_reg(CFG_INV_SCALE, $urandom_range(32'h0200_0000, 1));
    write_reg(CFG_EDGE_MARGIN, $urandom_range(32'h0004_0000));
    phase(100);
    wait_drained();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(CFG_INV_SCALE, $urandom_range(32'h0000_1000));
    write_reg(CFG_EDGE_MARGIN, $urandom);
    phase(50);
    wait_drained();
    write_reg(CFG_INV_SCALE, 32'h0080_0000);
    write_reg(CFG_EDGE_MARGIN, 32'd8090);
    phase(50);
    wait_drained();

    if (sb.errors == 0) $display("read_bias_loglik_uniform_tb: done, clean");
    else $display("read_bias_loglik_uniform_tb: done, errors");
    $finish;
  end
endmodule
